// File: src/cor_pkg.sv
package cor_pkg;

  localparam int COORD_BITS      = 11;
  localparam int COLOR_FRAC_BITS = 16;

  localparam int IN_CRD_W  = 11;
  localparam int SIZE_W    = 10;
  localparam int PIX_W     = 14;
  localparam int COL_W     = 8;
  localparam int MODE_W    = 2;
  localparam int FADE_W    = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam int RAD_W = COORD_BITS + 1;
  localparam int SQ_W  = 2 * COORD_BITS + 1;
  localparam int LVL_W = COLOR_FRAC_BITS + 1;
  localparam int CLV_W = COLOR_FRAC_BITS + 2;
  localparam int DVD_W = SIZE_W + COLOR_FRAC_BITS;
  localparam int DVS_W = RAD_W;

  // Size level is radius_size * ONE / 80, i.e. (radius_size << (F-4)) / 5.
  // It saturates from twice the divisor upwards; below that, a reciprocal
  // of five with two guard bits is exact over the SZ_X_W-bit operand.
  localparam int SIZE_SAT   = 160;
  localparam int SZ_X_W     = COLOR_FRAC_BITS + 4;
  localparam int SIZE_SHIFT = COLOR_FRAC_BITS + 6;
  localparam int SIZE_RECIP = ((1 << SIZE_SHIFT) + 4) / 5;

  typedef logic [LVL_W-1:0] lvl_t;
  typedef logic [CLV_W-1:0] clv_t;

  localparam lvl_t LVL_ONE = lvl_t'(1) << COLOR_FRAC_BITS;
  localparam lvl_t LVL_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLOR_MODE = 1'b0,
    CFG_FADE_STEP  = 1'b1
  } cfg_idx_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_FIXED = 2'd0,
    MODE_FADE  = 2'd1,
    MODE_SIZE  = 2'd2,
    MODE_RAMP  = 2'd3
  } mode_e;

  localparam mode_e MODE_RESET = MODE_RAMP;
  localparam logic [FADE_W-1:0] FADE_RESET = FADE_W'(917);

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_MUL_DX, OP_MUL_DY, OP_SQ_RAD, OP_RAD, OP_MUL_R, OP_R2,
    OP_WMUL, OP_SQ_DIFF, OP_WSTEP, OP_DIV_RAMP, OP_RAMP, OP_SIZE,
    OP_TICK, OP_RMUL, OP_RY
  } dp_op_e;

  typedef struct packed {
    logic active;
    logic slot_end;
    logic step_more;
    logic walk_more;
    logic sq_done;
    logic dv_done;
    logic out_busy;
  } sts_t;

  typedef struct packed {
    logic swap;
    logic neg_h;
    logic neg_v;
    clv_t red;
    clv_t green;
    clv_t blue;
  } pix_sel_t;

  // Clamp to full and scale to eight bits with rounding.
  function automatic logic [COL_W-1:0] to8_f(input clv_t lvl);
    clv_t c;
    logic [CLV_W+COL_W-1:0] p;
    c = (lvl > clv_t'(LVL_ONE)) ? clv_t'(LVL_ONE) : lvl;
    p = ((CLV_W+COL_W)'(c) << COL_W) - (CLV_W+COL_W)'(c)
        + ((CLV_W+COL_W)'(LVL_ONE) >> 1);
    return p[COLOR_FRAC_BITS+COL_W-1:COLOR_FRAC_BITS];
  endfunction

  function automatic pix_sel_t pix_sel_f(input mode_e mode, input logic [2:0] slot,
                                         input lvl_t fade, input lvl_t size,
                                         input lvl_t rise, input lvl_t fall);
    pix_sel_t s;
    clv_t one, lv, hl, rv, fv;
    logic [LVL_W+1:0] f3;
    one = clv_t'(LVL_ONE);
    rv  = clv_t'(rise);
    fv  = clv_t'(fall);
    f3  = (LVL_W+2)'(fall) + ((LVL_W+2)'(fall) << 1);
    unique case (mode)
      MODE_FIXED: lv = one;
      MODE_FADE:  lv = clv_t'(fade);
      MODE_SIZE:  lv = clv_t'(size);
      MODE_RAMP:  lv = one;
      default:    lv = one;
    endcase
    hl = lv >> 1;
    s = '0;
    if (mode == MODE_RAMP) begin
      unique case (slot)
        3'd0: begin s.neg_v = 1'b1; s.red = one; s.green = rv >> 1; end
        3'd1: begin s.swap = 1'b1; s.neg_v = 1'b1; s.red = one; s.green = fv; end
        3'd2: begin s.swap = 1'b1; s.red = fv; s.green = one; end
        3'd3: begin s.green = one; s.blue = fv; end
        3'd4: begin s.neg_h = 1'b1; s.green = fv; s.blue = one; end
        3'd5: begin
          s.swap = 1'b1; s.neg_h = 1'b1; s.red = clv_t'(f3 >> 2); s.blue = one;
        end
        3'd6: begin
          s.swap = 1'b1; s.neg_h = 1'b1; s.neg_v = 1'b1;
          s.red = (((one << 1) + one) >> 2) + rv; s.blue = one;
        end
        default: begin s.neg_h = 1'b1; s.neg_v = 1'b1; s.red = one; s.blue = rv; end
      endcase
    end else begin
      unique case (slot)
        3'd0: s.green = lv;
        3'd1: begin s.neg_h = 1'b1; s.green = lv; s.blue = lv; end
        3'd2: begin s.neg_h = 1'b1; s.neg_v = 1'b1; s.red = lv; s.blue = lv; end
        3'd3: begin s.neg_v = 1'b1; s.red = lv; end
        3'd4: begin s.swap = 1'b1; s.red = lv; s.green = lv; end
        3'd5: begin s.swap = 1'b1; s.neg_v = 1'b1; s.red = lv; s.green = hl; end
        3'd6: begin
          s.swap = 1'b1; s.neg_h = 1'b1; s.neg_v = 1'b1; s.red = hl; s.blue = hl;
        end
        default: begin s.swap = 1'b1; s.neg_h = 1'b1; s.blue = lv; end
      endcase
    end
    return s;
  endfunction

endpackage

// File: src/cor_if.sv
interface cor_in_if import cor_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                func;
  logic [IN_CRD_W-1:0] center_x;
  logic [IN_CRD_W-1:0] center_y;
  logic [IN_CRD_W-1:0] edge_x;
  logic [IN_CRD_W-1:0] edge_y;
  logic [SIZE_W-1:0]   radius_size;

  modport source (output valid, func, center_x, center_y, edge_x, edge_y, radius_size,
                  input ready);
  modport sink (input valid, func, center_x, center_y, edge_x, edge_y, radius_size,
                output ready);
endinterface

interface cor_out_if import cor_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [PIX_W-1:0] pixel_x;
  logic signed [PIX_W-1:0] pixel_y;
  logic [COL_W-1:0]        red;
  logic [COL_W-1:0]        green;
  logic [COL_W-1:0]        blue;
  logic                    last;

  modport source (output valid, pixel_x, pixel_y, red, green, blue, last, input ready);
  modport sink (input valid, pixel_x, pixel_y, red, green, blue, last, output ready);
endinterface

// File: src/cor_sqrt.sv
module cor_sqrt import cor_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SQ_W-1:0]  val_i,
  output logic             done_o,
  output logic [RAD_W-1:0] res_o
);

  logic              busy_q, done_q;
  logic [SQ_W-1:0]   val_q;
  logic [RAD_W-1:0]  res_q, res_d, bit_q;
  logic [RAD_W-1:0]  trial;
  logic [2*RAD_W-1:0] trial_sq;

  // One result bit a cycle, most significant first.
  assign trial    = res_q | bit_q;
  assign trial_sq = trial * trial;
  assign res_d    = (trial_sq <= (2*RAD_W)'(val_q)) ? trial : res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && bit_q[0];
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q <= val_i;
      res_q <= '0;
      bit_q <= {1'b1, {(RAD_W-1){1'b0}}};
    end else if (busy_q) begin
      res_q <= res_d;
      bit_q <= bit_q >> 1;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// File: src/cor_div.sv
module cor_div import cor_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dvd_i,
  input  logic [DVS_W-1:0] dvs_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy_q, done_q, fin;
  logic [CNT_W-1:0] cnt_q;
  logic [DVD_W-1:0] quo_q;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W:0]   rem_q, rem_sh;
  logic             qbit;

  // Restoring division, one quotient bit a cycle.
  assign rem_sh = {rem_q[DVS_W-1:0], quo_q[DVD_W-1]};
  assign qbit   = rem_sh >= {1'b0, dvs_q};
  assign fin    = busy_q && (cnt_q == CNT_W'(DVD_W - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (fin) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dvd_i;
      dvs_q <= dvs_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[DVD_W-2:0], qbit};
      rem_q <= qbit ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: src/cor_dp.sv
module cor_dp import cor_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_op_e               op_i,
  input  logic [IN_CRD_W-1:0]  center_x_i,
  input  logic [IN_CRD_W-1:0]  center_y_i,
  input  logic [IN_CRD_W-1:0]  edge_x_i,
  input  logic [IN_CRD_W-1:0]  edge_y_i,
  input  logic [SIZE_W-1:0]    radius_size_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output sts_t                 sts_o,
  cor_out_if.source            out_o
);

  mode_e                   mode_q;
  logic [FADE_W-1:0]       fstep_q;
  logic [COORD_BITS-1:0]   ctr_h_q, ctr_v_q, dx_q, dy_q;
  logic [COORD_BITS-1:0]   cx, cy, ex, ey;
  logic [SIZE_W-1:0]       size_in_q;
  logic [SQ_W-1:0]         acc_q, prod_q, r2_q, sq_in;
  logic [RAD_W-1:0]        rad_q, wx_q, cnt_q, sx_q, sy_q, mul_a, sq_res;
  logic [2*RAD_W-1:0]      mul_p;
  logic [2:0]              slot_q;
  lvl_t                    fade_q, rise_q, fall_q, ramp_q, size_q;
  logic [LVL_W:0]          rise_sum;
  logic                    active_q, out_valid_q, sq_done, dv_done;
  logic [DVD_W-1:0]        dv_dvd, dv_quo;
  logic [DVS_W-1:0]        dv_dvs;
  logic [SZ_X_W-1:0]       sz_x;
  logic [2*SZ_X_W-1:0]     sz_p;
  pix_sel_t                sel;
  logic [RAD_W-1:0]        hv, vv;
  logic [PIX_W-1:0]        h14, v14;

  assign cx = COORD_BITS'(center_x_i);
  assign cy = COORD_BITS'(center_y_i);
  assign ex = COORD_BITS'(edge_x_i);
  assign ey = COORD_BITS'(edge_y_i);

  always_comb begin
    unique case (op_i)
      OP_MUL_DX: mul_a = RAD_W'(dx_q);
      OP_MUL_DY: mul_a = RAD_W'(dy_q);
      OP_MUL_R:  mul_a = rad_q;
      OP_RMUL:   mul_a = sx_q;
      default:   mul_a = wx_q;
    endcase
  end
  assign mul_p = mul_a * mul_a;

  assign sq_in  = (op_i == OP_SQ_RAD) ? (acc_q + prod_q) : (r2_q - prod_q);
  assign dv_dvd = DVD_W'(LVL_ONE);
  assign dv_dvs = cnt_q;

  // Size level by reciprocal multiplication; only valid below saturation.
  assign sz_x = SZ_X_W'(size_in_q) << (COLOR_FRAC_BITS - 4);
  assign sz_p = (2*SZ_X_W)'(sz_x) * (2*SZ_X_W)'(SIZE_RECIP);

  cor_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (op_i == OP_SQ_RAD || op_i == OP_SQ_DIFF),
    .val_i   (sq_in),
    .done_o  (sq_done),
    .res_o   (sq_res)
  );

  cor_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (op_i == OP_DIV_RAMP),
    .dvd_i   (dv_dvd),
    .dvs_i   (dv_dvs),
    .done_o  (dv_done),
    .quo_o   (dv_quo)
  );

  assign sel = pix_sel_f(mode_q, slot_q, fade_q, size_q, rise_q, fall_q);
  assign hv  = sel.swap ? sy_q : sx_q;
  assign vv  = sel.swap ? sx_q : sy_q;
  assign h14 = PIX_W'(hv);
  assign v14 = PIX_W'(vv);
  assign rise_sum = {1'b0, rise_q} + {1'b0, ramp_q};

  assign sts_o.active    = active_q;
  assign sts_o.slot_end  = slot_q == 3'd7;
  assign sts_o.step_more = ({1'b0, sx_q} + 1'b1) <= {1'b0, sy_q};
  assign sts_o.walk_more = ({1'b0, wx_q} + 1'b1) <= {1'b0, sq_res};
  assign sts_o.sq_done   = sq_done;
  assign sts_o.dv_done   = dv_done;
  assign sts_o.out_busy  = out_valid_q && !out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_RESET;
      fstep_q     <= FADE_RESET;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
      ctr_h_q     <= '0;
      ctr_v_q     <= '0;
      rad_q       <= '0;
      sx_q        <= '0;
      sy_q        <= '0;
      slot_q      <= '0;
      fade_q      <= LVL_ONE;
      rise_q      <= '0;
      fall_q      <= LVL_ONE;
      ramp_q      <= '0;
      size_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_COLOR_MODE: mode_q  <= mode_e'(cfg_data_i[MODE_W-1:0]);
          CFG_FADE_STEP:  fstep_q <= cfg_data_i[FADE_W-1:0];
          default:        mode_q  <= mode_q;
        endcase
      end
      if (out_o.ready) out_valid_q <= 1'b0;
      unique case (op_i)
        OP_LATCH: begin
          ctr_h_q  <= cx;
          ctr_v_q  <= cy;
          active_q <= 1'b0;
        end
        OP_RAD:  rad_q  <= sq_res;
        OP_RAMP: ramp_q <= dv_quo[LVL_W-1:0];
        OP_SIZE: begin
          size_q   <= (size_in_q >= SIZE_W'(SIZE_SAT)) ? LVL_MAX
                                                       : lvl_t'(sz_p >> SIZE_SHIFT);
          sx_q     <= '0;
          sy_q     <= rad_q;
          slot_q   <= '0;
          fade_q   <= LVL_ONE;
          rise_q   <= '0;
          fall_q   <= LVL_ONE;
          active_q <= 1'b1;
        end
        OP_TICK: begin
          if (active_q) begin
            out_valid_q <= 1'b1;
            slot_q      <= slot_q + 1'b1;
            if (slot_q == 3'd7) begin
              fade_q <= (fade_q > lvl_t'(fstep_q)) ? fade_q - lvl_t'(fstep_q) : '0;
              rise_q <= rise_sum[LVL_W] ? LVL_MAX : rise_sum[LVL_W-1:0];
              fall_q <= (fall_q > ramp_q) ? fall_q - ramp_q : '0;
              if (sts_o.step_more) begin
                sx_q <= sx_q + 1'b1;
              end else begin
                active_q <= 1'b0;
              end
            end
          end
        end
        OP_RY:   sy_q <= sq_res;
        default: active_q <= active_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (op_i)
      OP_LATCH: begin
        dx_q      <= (ex > cx) ? ex - cx : cx - ex;
        dy_q      <= (ey > cy) ? ey - cy : cy - ey;
        size_in_q <= radius_size_i;
      end
      OP_MUL_DX, OP_MUL_R, OP_WMUL, OP_RMUL: prod_q <= mul_p[SQ_W-1:0];
      OP_MUL_DY: begin
        acc_q  <= prod_q;
        prod_q <= mul_p[SQ_W-1:0];
      end
      OP_R2: begin
        r2_q  <= prod_q;
        wx_q  <= '0;
        cnt_q <= RAD_W'(1);
      end
      OP_WSTEP: begin
        wx_q  <= wx_q + 1'b1;
        cnt_q <= cnt_q + 1'b1;
      end
      OP_TICK: begin
        out_o.pixel_x <= PIX_W'(ctr_h_q) + (sel.neg_h ? -h14 : h14);
        out_o.pixel_y <= PIX_W'(ctr_v_q) + (sel.neg_v ? -v14 : v14);
        out_o.red     <= to8_f(sel.red);
        out_o.green   <= to8_f(sel.green);
        out_o.blue    <= to8_f(sel.blue);
        out_o.last    <= (slot_q == 3'd7) && !sts_o.step_more;
      end
      default: acc_q <= acc_q;
    endcase
  end

  assign out_o.valid = out_valid_q;

endmodule

// File: src/cor_ctrl.sv
module cor_ctrl import cor_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  input  logic   in_func_i,
  output logic   in_ready_o,
  input  sts_t   sts_i,
  output dp_op_e op_o
);

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_MDX   = 16'h0002,
    S_MDY   = 16'h0004,
    S_SQR   = 16'h0008,
    S_WR    = 16'h0010,
    S_R2    = 16'h0020,
    S_R2L   = 16'h0040,
    S_WMUL  = 16'h0080,
    S_WSQ   = 16'h0100,
    S_WWAIT = 16'h0200,
    S_DVR   = 16'h0400,
    S_WDVR  = 16'h0800,
    S_DVS   = 16'h1000,
    S_RMUL  = 16'h2000,
    S_RSQ   = 16'h4000,
    S_RWAIT = 16'h8000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE) && !sts_i.out_busy;

  always_comb begin
    state_d = state_q;
    op_o    = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          if (!in_func_i) begin
            op_o    = OP_LATCH;
            state_d = S_MDX;
          end else begin
            op_o = OP_TICK;
            if (sts_i.active && sts_i.slot_end && sts_i.step_more) state_d = S_RMUL;
          end
        end
      end
      S_MDX: begin op_o = OP_MUL_DX; state_d = S_MDY; end
      S_MDY: begin op_o = OP_MUL_DY; state_d = S_SQR; end
      S_SQR: begin op_o = OP_SQ_RAD; state_d = S_WR; end
      S_WR: begin
        if (sts_i.sq_done) begin op_o = OP_RAD; state_d = S_R2; end
      end
      S_R2:   begin op_o = OP_MUL_R; state_d = S_R2L; end
      S_R2L:  begin op_o = OP_R2; state_d = S_WMUL; end
      S_WMUL: begin op_o = OP_WMUL; state_d = S_WSQ; end
      S_WSQ:  begin op_o = OP_SQ_DIFF; state_d = S_WWAIT; end
      S_WWAIT: begin
        // Count one step, loop while the next x stays within y.
        if (sts_i.sq_done) begin
          op_o    = OP_WSTEP;
          state_d = sts_i.walk_more ? S_WMUL : S_DVR;
        end
      end
      S_DVR: begin op_o = OP_DIV_RAMP; state_d = S_WDVR; end
      S_WDVR: begin
        if (sts_i.dv_done) begin op_o = OP_RAMP; state_d = S_DVS; end
      end
      S_DVS:  begin op_o = OP_SIZE; state_d = S_IDLE; end
      S_RMUL: begin op_o = OP_RMUL; state_d = S_RSQ; end
      S_RSQ:  begin op_o = OP_SQ_DIFF; state_d = S_RWAIT; end
      S_RWAIT: begin
        if (sts_i.sq_done) begin op_o = OP_RY; state_d = S_IDLE; end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == S_IDLE)
    else $error("input ready outside idle");

  a_sq_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.sq_done |-> (state_q == S_WR || state_q == S_WWAIT || state_q == S_RWAIT))
    else $error("root finished while not awaited");

  a_dv_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.dv_done |-> state_q == S_WDVR)
    else $error("quotient finished while not awaited");

  a_size_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_o == OP_SIZE |=> state_q == S_IDLE && sts_i.active)
    else $error("circle not armed after set-up");

endmodule

// File: src/circle_octant_rasterizer_gradient_unit.sv
// Eight-way symmetric circle rasteriser with colour gradients.
// in_i carries items: func 0 starts a circle from a centre and an edge point,
// func 1 is a tick that asks for the next pixel. out_o carries one pixel beat
// per tick while a circle runs; last marks the final pixel. Ticks with no
// circle running are taken and give nothing.
// cfg_we_i/cfg_idx_i/cfg_data_i write colour_mode (0) and fade_step (1).
// A tick's pixel appears in the output register the cycle after acceptance.
// Seven ticks in eight are taken back to back while out_o does not stall; the
// eighth also advances the step, if one follows, and then holds input off
// while the shared root unit forms the next y.
// A start walks every step first, finding the radius and each step's y with
// the bit-serial root unit and the ramp increment with the divider unit.
// Input is held off while a pixel beat waits and out_o.ready is low.
// Reset leaves no circle running, colour_mode 3 and fade_step 917.
module circle_octant_rasterizer_gradient_unit import cor_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  cor_in_if.sink               in_i,
  cor_out_if.source            out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  dp_op_e op;
  sts_t   sts;

  cor_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_func_i  (in_i.func),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .op_o       (op)
  );

  cor_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .center_x_i    (in_i.center_x),
    .center_y_i    (in_i.center_y),
    .edge_x_i      (in_i.edge_x),
    .edge_y_i      (in_i.edge_y),
    .radius_size_i (in_i.radius_size),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .sts_o         (sts),
    .out_o         (out_o)
  );

endmodule

// File: tb/cor_pixel_checker.sv
module cor_pixel_checker import cor_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  cor_in_if                    in_mon,
  cor_out_if                   out_mon,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output int                   mismatches_o,
  output int                   pixels_waiting_o,
  output int                   pixels_seen_o
);

  typedef struct {
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] py;
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
    logic             last;
  } pixel_t;

  pixel_t pixel_q[$];

  mode_e             cur_mode;
  logic [FADE_W-1:0] cur_fade_step;

  logic              running;
  logic [10:0]       ctr_h, ctr_v;
  logic [11:0]       rad, sx, sy;
  logic [2:0]        slot;
  logic [16:0]       fade_lv, rise_lv, fall_lv, ramp_inc, size_lv;

  localparam longint unsigned ONE_L = 65536;
  localparam longint unsigned TOP_L = 131071;

  assign pixels_waiting_o = pixel_q.size();

  function automatic longint unsigned int_root(input longint unsigned v);
    longint unsigned rt, cand;
    rt = 0;
    for (int b = 31; b >= 0; b--) begin
      cand = rt | (longint'(1) << b);
      if (cand * cand <= v) rt = cand;
    end
    return rt;
  endfunction

  function automatic logic [COL_W-1:0] level_to_byte(input longint unsigned lv);
    longint unsigned c;
    c = (lv > ONE_L) ? ONE_L : lv;
    return COL_W'((c * 255 + ONE_L / 2) >> 16);
  endfunction

  task automatic latch_circle();
    longint unsigned cx, cy, ex, ey, dx, dy, r, x, y, cnt, sz;
    cx = longint'(in_mon.center_x); cy = longint'(in_mon.center_y);
    ex = longint'(in_mon.edge_x);   ey = longint'(in_mon.edge_y);
    dx = ex > cx ? ex - cx : cx - ex;
    dy = ey > cy ? ey - cy : cy - ey;
    r = int_root(dx * dx + dy * dy);
    x = 0;
    cnt = 1;
    // walk every step once to size the ramps
    do begin
      y = int_root(r * r - x * x);
      x++;
      cnt++;
    end while (x <= y);
    sz = (longint'(in_mon.radius_size) << 16) / 80;
    ctr_h = 11'(cx); ctr_v = 11'(cy); rad = 12'(r);
    sx = '0; sy = 12'(r); slot = '0;
    fade_lv = 17'(ONE_L); rise_lv = '0; fall_lv = 17'(ONE_L);
    ramp_inc = 17'(ONE_L / cnt);
    size_lv = 17'(sz > TOP_L ? TOP_L : sz);
    running = 1'b1;
  endtask

  task automatic emit_pixel();
    longint ox, oy, x, y;
    longint unsigned rr, gg, bb, lv, rs, fl, nx, t;
    pixel_t p;
    x = longint'(sx); y = longint'(sy);
    rr = 0; gg = 0; bb = 0;
    rs = longint'(rise_lv); fl = longint'(fall_lv);
    if (cur_mode == MODE_RAMP) begin
      case (slot)
        3'd0: begin ox = x;  oy = -y; rr = ONE_L; gg = rs >> 1; end
        3'd1: begin ox = y;  oy = -x; rr = ONE_L; gg = fl; end
        3'd2: begin ox = y;  oy = x;  rr = fl; gg = ONE_L; end
        3'd3: begin ox = x;  oy = y;  gg = ONE_L; bb = fl; end
        3'd4: begin ox = -x; oy = y;  gg = fl; bb = ONE_L; end
        3'd5: begin ox = -y; oy = x;  rr = (fl * 3) >> 2; bb = ONE_L; end
        3'd6: begin ox = -y; oy = -x; rr = ((ONE_L * 3) >> 2) + rs; bb = ONE_L; end
        default: begin ox = -x; oy = -y; rr = ONE_L; bb = rs; end
      endcase
    end else begin
      lv = (cur_mode == MODE_FIXED) ? ONE_L :
           (cur_mode == MODE_FADE) ? longint'(fade_lv) : longint'(size_lv);
      case (slot)
        3'd0: begin ox = x;  oy = y;  gg = lv; end
        3'd1: begin ox = -x; oy = y;  gg = lv; bb = lv; end
        3'd2: begin ox = -x; oy = -y; rr = lv; bb = lv; end
        3'd3: begin ox = x;  oy = -y; rr = lv; end
        3'd4: begin ox = y;  oy = x;  rr = lv; gg = lv; end
        3'd5: begin ox = y;  oy = -x; rr = lv; gg = lv >> 1; end
        3'd6: begin ox = -y; oy = -x; rr = lv >> 1; bb = lv >> 1; end
        default: begin ox = -y; oy = x; bb = lv; end
      endcase
    end
    p.px = PIX_W'(longint'(ctr_h) + ox);
    p.py = PIX_W'(longint'(ctr_v) + oy);
    p.red = level_to_byte(rr);
    p.green = level_to_byte(gg);
    p.blue = level_to_byte(bb);
    p.last = 1'b0;
    if (slot != 3'd7) begin
      slot = slot + 3'd1;
    end else begin
      slot = '0;
      fade_lv = (fade_lv > 17'(cur_fade_step)) ? fade_lv - 17'(cur_fade_step) : '0;
      t = longint'(rise_lv) + longint'(ramp_inc);
      rise_lv = 17'(t > TOP_L ? TOP_L : t);
      fall_lv = (fall_lv > ramp_inc) ? fall_lv - ramp_inc : '0;
      nx = longint'(sx) + 1;
      if (nx <= longint'(sy)) begin
        sx = 12'(nx);
        sy = 12'(int_root(longint'(rad) * longint'(rad) - nx * nx));
      end else begin
        running = 1'b0;
        p.last = 1'b1;
      end
    end
    pixel_q.push_back(p);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t want;
    if (!rst_ni) begin
      pixel_q.delete();
      cur_mode = MODE_RESET; cur_fade_step = FADE_RESET;
      running = 1'b0; ctr_h = '0; ctr_v = '0; rad = '0; sx = '0; sy = '0; slot = '0;
      fade_lv = 17'(ONE_L); rise_lv = '0; fall_lv = 17'(ONE_L); ramp_inc = '0;
      size_lv = '0;
      mismatches_o <= 0;
      pixels_seen_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_COLOR_MODE) cur_mode = mode_e'(cfg_data_i[MODE_W-1:0]);
        else cur_fade_step = cfg_data_i[FADE_W-1:0];
      end
      // check the result beat before predicting from this edge's input beat
      if (out_mon.valid && out_mon.ready) begin
        pixels_seen_o <= pixels_seen_o + 1;
        if (pixel_q.size() == 0) begin
          $display("%0t: unexpected pixel x=%0d y=%0d", $time, out_mon.pixel_x,
                   out_mon.pixel_y);
          mismatches_o <= mismatches_o + 1;
        end else begin
          want = pixel_q.pop_front();
          if (out_mon.pixel_x !== want.px || out_mon.pixel_y !== want.py ||
              out_mon.red !== want.red || out_mon.green !== want.green ||
              out_mon.blue !== want.blue || out_mon.last !== want.last) begin
            $display("%0t: expected x=%0d y=%0d rgb=%0d,%0d,%0d last=%0b", $time,
                     $signed(want.px), $signed(want.py), want.red, want.green,
                     want.blue, want.last);
            $display("%0t: actual   x=%0d y=%0d rgb=%0d,%0d,%0d last=%0b", $time,
                     out_mon.pixel_x, out_mon.pixel_y, out_mon.red, out_mon.green,
                     out_mon.blue, out_mon.last);
            mismatches_o <= mismatches_o + 1;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (!in_mon.func) latch_circle();
        else if (running) emit_pixel();
      end
    end
  end

endmodule

// File: tb/testbench.sv
module testbench;
  import cor_pkg::*;

  localparam int STALL_LIMIT = 150000;
  localparam int PHASE_ITEMS = 160;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  int mismatches, pixels_waiting, pixels_seen;
  int items_sent, starts_sent, lasts_seen, quiet_cycles;
  logic quiet, hold_req, hold_done;
  int stall_left;

  cor_in_if  in_if();
  cor_out_if out_if();

  always #2 clk_i = ~clk_i;

  circle_octant_rasterizer_gradient_unit dut (
    .clk_i, .rst_ni, .in_i(in_if), .out_o(out_if),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  cor_pixel_checker chk (
    .clk_i, .rst_ni, .in_mon(in_if), .out_mon(out_if),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .mismatches_o(mismatches), .pixels_waiting_o(pixels_waiting),
    .pixels_seen_o(pixels_seen)
  );

  always @(posedge clk_i)
    if (out_if.valid && out_if.ready && out_if.last) lasts_seen <= lasts_seen + 1;

  // receiver side: random back-pressure, one long hold on request
  always @(posedge clk_i or negedge rst_ni) begin
    int r;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      stall_left <= 400;
      out_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_if.ready <= 1'b0;
    end else if (quiet) begin
      out_if.ready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 10) stall_left <= $urandom_range(0, 2);
      else if (r == 10) stall_left <= $urandom_range(15, 60);
      out_if.ready <= (r > 10);
    end
  end

  // watchdog: cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_beat(input logic f, input int cx, input int cy, input int ex,
                           input int ey, input int sz);
    int gap, r;
    r = $urandom_range(0, 99);
    gap = quiet ? 0 : (r < 60) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 50);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.func <= f;
    in_if.center_x <= IN_CRD_W'(cx); in_if.center_y <= IN_CRD_W'(cy);
    in_if.edge_x <= IN_CRD_W'(ex);   in_if.edge_y <= IN_CRD_W'(ey);
    in_if.radius_size <= SIZE_W'(sz);
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
    if (!f) starts_sent++;
  endtask

  task automatic tick();
    send_beat(1'b1, $urandom_range(0, 2047), $urandom_range(0, 2047),
              $urandom_range(0, 2047), $urandom_range(0, 2047), $urandom_range(0, 1023));
  endtask

  // start a circle; stop_after < 0 runs it to its last pixel, else abandon
  task automatic run_circle(input int cx, input int cy, input int ex, input int ey,
                            input int sz, input int stop_after);
    int mark;
    mark = lasts_seen;
    send_beat(1'b0, cx, cy, ex, ey, sz);
    if (stop_after >= 0) repeat (stop_after) tick();
    else while (lasts_seen == mark) tick();
  endtask

  task automatic drain_all();
    in_if.valid <= 1'b0;
    while (pixels_waiting != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic int near(input int c, input int span);
    int v;
    v = c + $urandom_range(0, 2 * span) - span;
    return v < 0 ? 0 : v > 2047 ? 2047 : v;
  endfunction

  task automatic random_circle();
    int cx, cy, sz, r, span;
    cx = $urandom_range(0, 2047);
    cy = $urandom_range(0, 2047);
    sz = $urandom_range(0, 1023);
    r = $urandom_range(0, 199);
    if (r < 3) begin
      run_circle(cx, cy, $urandom_range(0, 2047), $urandom_range(0, 2047), sz,
                 $urandom_range(0, 10));
    end else begin
      span = (r < 12) ? 40 : 7;
      run_circle(cx, cy, near(cx, span), near(cy, span), sz,
                 (r < 25) ? $urandom_range(0, 20) : -1);
      if (r >= 190) repeat ($urandom_range(1, 3)) tick();
    end
  endtask

  initial begin
    int phase_end;
    mode_e mode_set[8];
    logic [FADE_W-1:0] fade_set[8];
    mode_set = '{MODE_FIXED, MODE_FADE, MODE_FADE, MODE_SIZE, MODE_RAMP, MODE_FADE,
                 MODE_SIZE, MODE_RAMP};
    fade_set = '{16'd0, 16'hFFFF, 16'd0, 16'd1, 16'd917, 16'd0, 16'd0, 16'd0};
    fade_set[5] = FADE_W'($urandom_range(1, 8000));
    fade_set[6] = FADE_W'($urandom_range(0, 65535));
    fade_set[7] = FADE_W'($urandom_range(0, 65535));
    in_if.valid <= 1'b0; in_if.func <= 1'b0;
    in_if.center_x <= '0; in_if.center_y <= '0; in_if.edge_x <= '0; in_if.edge_y <= '0;
    in_if.radius_size <= '0;
    cfg_we <= 1'b0; cfg_idx <= CFG_COLOR_MODE; cfg_data <= '0;
    quiet <= 1'b0; hold_req <= 1'b0;
    items_sent = 0; starts_sent = 0; lasts_seen = 0; quiet_cycles = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings, idle tick, zero radius, wrap, extremes, abandon
    tick();
    run_circle(1000, 1000, 1000, 1000, 0, -1);
    run_circle(0, 0, 3, 4, 1023, -1);
    run_circle(2047, 2047, 2042, 2047, 512, -1);
    tick();
    run_circle(0, 0, 2047, 2047, 1023, 12);
    run_circle(2047, 0, 2040, 7, 80, -1);
    drain_all();

    // back-pressure: long receiver hold while ticks keep coming
    hold_req <= 1'b1;
    run_circle(600, 600, 620, 611, 300, -1);
    drain_all();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_COLOR_MODE, CFG_W'(mode_set[ph]));
      write_reg(CFG_FADE_STEP, fade_set[ph]);
      quiet <= (ph == 3);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) random_circle();
      drain_all();
    end

    $display("%0d beats sent (%0d starts), %0d pixels checked, %0d circles finished",
             items_sent, starts_sent, pixels_seen, lasts_seen);
    $display("covered all four colour modes, fade step extremes, wrap and abandon");
    if (mismatches == 0 && pixels_waiting == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
